// ----- rtl/sme_pkg.sv -----
// Shared types, codes and decode helpers for the stack machine executor.
package sme_pkg;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_IGNORED = 3'd2;
	localparam logic [2:0] ST_UNDER   = 3'd3;
	localparam logic [2:0] ST_OVER    = 3'd4;
	localparam logic [2:0] ST_DIVZERO = 3'd5;
	localparam logic [2:0] ST_NEGROOT = 3'd6;
	localparam logic [2:0] ST_INVALID = 3'd7;

	localparam logic [1:0] K_PUSH = 2'd0;
	localparam logic [1:0] K_PRIM = 2'd1;
	localparam logic [1:0] K_NEG  = 2'd2;
	localparam logic [1:0] K_BAD  = 2'd3;

	localparam logic [29:0] OP_LAST = 30'd33;
	localparam logic [29:0] OP_RAND = 30'd11;

	localparam logic [5:0] OP_HALT = 6'd0;
	localparam logic [5:0] OP_ADD  = 6'd1;
	localparam logic [5:0] OP_SUB  = 6'd2;
	localparam logic [5:0] OP_MUL  = 6'd3;
	localparam logic [5:0] OP_DIV  = 6'd4;
	localparam logic [5:0] OP_MOD  = 6'd5;
	localparam logic [5:0] OP_SQRT = 6'd6;
	localparam logic [5:0] OP_CBRT = 6'd7;
	localparam logic [5:0] OP_POW  = 6'd8;
	localparam logic [5:0] OP_MIN  = 6'd9;
	localparam logic [5:0] OP_MAX  = 6'd10;
	localparam logic [5:0] OP_AND  = 6'd12;
	localparam logic [5:0] OP_OR   = 6'd13;
	localparam logic [5:0] OP_XOR  = 6'd14;
	localparam logic [5:0] OP_NOT  = 6'd15;
	localparam logic [5:0] OP_SHL  = 6'd16;
	localparam logic [5:0] OP_SHR  = 6'd17;
	localparam logic [5:0] OP_NEGT = 6'd18;
	localparam logic [5:0] OP_LT   = 6'd19;
	localparam logic [5:0] OP_LE   = 6'd20;
	localparam logic [5:0] OP_GT   = 6'd21;
	localparam logic [5:0] OP_GE   = 6'd22;
	localparam logic [5:0] OP_EQ   = 6'd23;
	localparam logic [5:0] OP_NE   = 6'd24;
	localparam logic [5:0] OP_SWAP = 6'd25;
	localparam logic [5:0] OP_INC  = 6'd26;
	localparam logic [5:0] OP_DEC  = 6'd27;
	localparam logic [5:0] OP_BTST = 6'd28;
	localparam logic [5:0] OP_BCLR = 6'd29;
	localparam logic [5:0] OP_BSET = 6'd30;
	localparam logic [5:0] OP_POP  = 6'd31;
	localparam logic [5:0] OP_EVEN = 6'd32;
	localparam logic [5:0] OP_ODD  = 6'd33;

	typedef enum logic [2:0] {
		U_MUL,
		U_DIV,
		U_MOD,
		U_SQRT,
		U_CBRT,
		U_POW
	} uop_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEC,
		S_OPER,
		S_ITER
	} state_t;

	typedef struct packed {
		logic load_ir;
		logic commit;
		logic start;
	} cmd_t;

	typedef struct packed {
		logic go_oper;
		logic go_long;
		logic unit_done;
	} sts_t;

	function automatic logic need_two(input logic [5:0] op);
		logic r;
		case (op) inside
			[OP_ADD:OP_MOD], [OP_POW:OP_XOR], OP_SHL, OP_SHR,
			[OP_LT:OP_SWAP], [OP_BTST:OP_BSET]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/sme_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module sme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ----- rtl/sme_iter.sv -----
// Iterative unit: multiply, divide/modulo, square root, cube root, power.
module sme_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sme_pkg::uop_t      uop,
	input  logic [31:0]        opa,
	input  logic [31:0]        opb,
	output logic               done,
	output logic [31:0]        res
);
	import sme_pkg::*;

	uop_t        mode_q;
	logic        busy_q, done_q, ph_q, na_q, nb_q;
	logic [31:0] x_q, y_q, acc_q, r_q, rem_q, sq_q, res_q;
	logic [4:0]  cnt_q;

	logic [31:0] t, m_a, m_b, qn, rn, rt;
	logic [63:0] prod;
	logic [32:0] rr, diff;
	logic        ge, fit;

	assign t    = r_q | (32'd1 << cnt_q);
	assign rr   = {rem_q, x_q[31]};
	assign diff = rr - {1'b0, y_q};
	assign ge   = rr >= {1'b0, y_q};
	assign qn   = {x_q[30:0], ge};
	assign rn   = ge ? diff[31:0] : rr[31:0];
	assign fit  = prod <= {32'd0, x_q};
	assign rt   = fit ? t : r_q;
	assign prod = {32'd0, m_a} * {32'd0, m_b};

	always_comb begin
		m_a = 32'd0;
		m_b = 32'd0;
		case (mode_q)
			U_MUL: begin
				m_a = x_q;
				m_b = y_q;
			end
			U_SQRT: begin
				m_a = t;
				m_b = t;
			end
			U_CBRT: begin
				m_a = ph_q ? sq_q : t;
				m_b = t;
			end
			U_POW: begin
				m_a = ph_q ? x_q : acc_q;
				m_b = x_q;
			end
			default: begin
				m_a = 32'd0;
				m_b = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			case (mode_q)
				U_MUL: begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				U_DIV, U_MOD, U_SQRT: begin
					if (cnt_q == 5'd0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				U_CBRT: begin
					if (ph_q && cnt_q == 5'd0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				U_POW: begin
					if (!ph_q && y_q == 32'd0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				default: begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= uop;
			ph_q   <= 1'b0;
			acc_q  <= 32'd1;
			r_q    <= 32'd0;
			rem_q  <= 32'd0;
			na_q   <= opa[31];
			nb_q   <= opb[31];
			case (uop)
				U_DIV, U_MOD: begin
					x_q   <= opa[31] ? 32'd0 - opa : opa;
					y_q   <= opb[31] ? 32'd0 - opb : opb;
					cnt_q <= 5'd31;
				end
				U_SQRT: begin
					x_q   <= opb;
					y_q   <= opb;
					cnt_q <= 5'd15;
				end
				U_CBRT: begin
					x_q   <= opb[31] ? 32'd0 - opb : opb;
					y_q   <= opb;
					cnt_q <= 5'd10;
				end
				default: begin
					x_q   <= opa;
					y_q   <= opb;
					cnt_q <= 5'd31;
				end
			endcase
		end else if (busy_q) begin
			case (mode_q)
				U_MUL: res_q <= prod[31:0];
				U_DIV, U_MOD: begin
					rem_q <= rn;
					x_q   <= qn;
					cnt_q <= cnt_q - 5'd1;
					if (mode_q == U_DIV) begin
						res_q <= (na_q ^ nb_q) ? 32'd0 - qn : qn;
					end else begin
						res_q <= na_q ? 32'd0 - rn : rn;
					end
				end
				U_SQRT: begin
					r_q   <= rt;
					res_q <= rt;
					cnt_q <= cnt_q - 5'd1;
				end
				U_CBRT: begin
					if (!ph_q) begin
						sq_q <= prod[31:0];
						ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						r_q   <= rt;
						res_q <= nb_q ? 32'd0 - rt : rt;
						cnt_q <= cnt_q - 5'd1;
					end
				end
				U_POW: begin
					res_q <= acc_q;
					if (!ph_q) begin
						if (y_q != 32'd0) begin
							if (y_q[0]) begin
								acc_q <= prod[31:0];
							end
							ph_q <= 1'b1;
						end
					end else begin
						x_q  <= prod[31:0];
						y_q  <= {1'b0, y_q[31:1]};
						ph_q <= 1'b0;
					end
				end
				default: res_q <= 32'd0;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

// ----- rtl/sme_dpath.sv -----
// Datapath: instruction register, top-of-stack register, stack RAM, result registers.
module sme_dpath #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sme_pkg::cmd_t       cmd,
	output sme_pkg::sts_t       sts,
	input  logic [31:0]         instruction_word,
	output logic signed [31:0]  top_value,
	output logic [8:0]          stack_depth,
	output logic [2:0]          status
);
	import sme_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);

	logic [31:0]    ir_q, tos_q;
	logic [SPW-1:0] sp_q;
	logic           halt_q;
	logic [31:0]    out_top_q;
	logic [8:0]     out_depth_q;
	logic [2:0]     out_status_q;

	logic [1:0]     kind;
	logic [29:0]    pl;
	logic [5:0]     op;
	logic [31:0]    a, b, ures;
	logic [4:0]     sh;
	logic           two;
	logic [31:0]    nx_tos, wr_data;
	logic [SPW-1:0] nx_sp;
	logic           nx_halt, wr_en, go_oper, go_long, unit_done;
	logic [2:0]     nx_st;
	logic [AW-1:0]  wr_addr, rd_addr;
	uop_t           uop;

	assign kind    = ir_q[31:30];
	assign pl      = ir_q[29:0];
	assign op      = pl[5:0];
	assign b       = tos_q;
	assign sh      = tos_q[4:0];
	assign two     = need_two(op);
	assign rd_addr = AW'(sp_q - SPW'(2));

	sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.commit & wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (a)
	);

	sme_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.uop    (uop),
		.opa    (a),
		.opb    (b),
		.done   (unit_done),
		.res    (ures)
	);

	always_comb begin
		nx_tos  = tos_q;
		nx_sp   = sp_q;
		nx_halt = halt_q;
		nx_st   = ST_OK;
		wr_en   = 1'b0;
		wr_addr = rd_addr;
		wr_data = tos_q;
		go_oper = 1'b0;
		go_long = 1'b0;
		uop     = U_MUL;
		if (halt_q) begin
			nx_st = ST_IGNORED;
		end else if (kind == K_PUSH || kind == K_NEG) begin
			if (sp_q >= SPW'(STACK_DEPTH)) begin
				nx_st = ST_OVER;
			end else begin
				wr_en   = sp_q != '0;
				wr_addr = AW'(sp_q - SPW'(1));
				nx_tos  = (kind == K_NEG) ? 32'd0 - {2'b00, pl} : {2'b00, pl};
				nx_sp   = sp_q + SPW'(1);
			end
		end else if (kind == K_PRIM) begin
			if (pl > OP_LAST || pl == OP_RAND) begin
				nx_st = ST_INVALID;
			end else if (op == OP_HALT) begin
				nx_halt = 1'b1;
				nx_st   = ST_HALT;
			end else if (sp_q < (two ? SPW'(2) : SPW'(1))) begin
				nx_st = ST_UNDER;
			end else begin
				if (two) begin
					go_oper = 1'b1;
					nx_sp   = sp_q - SPW'(1);
				end
				case (op)
					OP_ADD:  nx_tos = a + b;
					OP_SUB:  nx_tos = a - b;
					OP_MUL: begin
						go_long = 1'b1;
						nx_tos  = ures;
					end
					OP_DIV, OP_MOD: begin
						if (b == 32'd0) begin
							go_oper = 1'b0;
							nx_sp   = sp_q;
							nx_st   = ST_DIVZERO;
						end else begin
							go_long = 1'b1;
							uop     = (op == OP_DIV) ? U_DIV : U_MOD;
							nx_tos  = ures;
						end
					end
					OP_SQRT: begin
						if (b[31]) begin
							nx_st = ST_NEGROOT;
						end else begin
							go_long = 1'b1;
							uop     = U_SQRT;
							nx_tos  = ures;
						end
					end
					OP_CBRT: begin
						go_long = 1'b1;
						uop     = U_CBRT;
						nx_tos  = ures;
					end
					OP_POW: begin
						if (!b[31]) begin
							go_long = 1'b1;
							uop     = U_POW;
							nx_tos  = ures;
						end else if (a == 32'd0) begin
							nx_sp = sp_q;
							nx_st = ST_DIVZERO;
						end else if (a == 32'd1) begin
							nx_tos = 32'd1;
						end else if (a == 32'hffff_ffff) begin
							nx_tos = b[0] ? 32'hffff_ffff : 32'd1;
						end else begin
							nx_tos = 32'd0;
						end
					end
					OP_MIN:  nx_tos = ($signed(a) < $signed(b)) ? a : b;
					OP_MAX:  nx_tos = ($signed(a) > $signed(b)) ? a : b;
					OP_AND:  nx_tos = a & b;
					OP_OR:   nx_tos = a | b;
					OP_XOR:  nx_tos = a ^ b;
					OP_NOT:  nx_tos = ~b;
					OP_SHL:  nx_tos = a << sh;
					OP_SHR:  nx_tos = 32'($signed(a) >>> sh);
					OP_NEGT: nx_tos = 32'd0 - b;
					OP_LT:   nx_tos = {31'd0, $signed(a) < $signed(b)};
					OP_LE:   nx_tos = {31'd0, $signed(a) <= $signed(b)};
					OP_GT:   nx_tos = {31'd0, $signed(a) > $signed(b)};
					OP_GE:   nx_tos = {31'd0, $signed(a) >= $signed(b)};
					OP_EQ:   nx_tos = {31'd0, a == b};
					OP_NE:   nx_tos = {31'd0, a != b};
					OP_SWAP: begin
						nx_sp   = sp_q;
						wr_en   = 1'b1;
						wr_data = b;
						nx_tos  = a;
					end
					OP_INC:  nx_tos = b + 32'd1;
					OP_DEC:  nx_tos = b - 32'd1;
					OP_BTST: nx_tos = {31'd0, a[sh]};
					OP_BCLR: nx_tos = a & ~(32'd1 << sh);
					OP_BSET: nx_tos = a | (32'd1 << sh);
					OP_POP: begin
						nx_sp = sp_q - SPW'(1);
						if (sp_q >= SPW'(2)) begin
							go_oper = 1'b1;
							nx_tos  = a;
						end else begin
							nx_tos = 32'd0;
						end
					end
					OP_EVEN: nx_tos = {31'd0, ~b[0]};
					OP_ODD:  nx_tos = {31'd0, b[0]};
					default: nx_st = ST_INVALID;
				endcase
				if (go_long) begin
					go_oper = 1'b1;
				end
			end
		end else begin
			nx_st = ST_INVALID;
		end
	end

	assign sts = '{go_oper: go_oper, go_long: go_long, unit_done: unit_done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			halt_q <= 1'b0;
		end else if (cmd.commit) begin
			sp_q   <= nx_sp;
			halt_q <= nx_halt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_ir) begin
			ir_q <= instruction_word;
		end
		if (cmd.commit) begin
			tos_q        <= nx_tos;
			out_top_q    <= (nx_sp == '0) ? 32'd0 : nx_tos;
			out_depth_q  <= 9'(nx_sp);
			out_status_q <= nx_st;
		end
	end

	assign top_value   = $signed(out_top_q);
	assign stack_depth = out_depth_q;
	assign status      = out_status_q;
endmodule

// ----- rtl/sme_ctrl.sv -----
// Controller: item sequencing and output handshake.
module sme_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  sme_pkg::sts_t sts,
	output sme_pkg::cmd_t cmd
);
	import sme_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_ir = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.go_oper) begin
					state_d = S_OPER;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_OPER: begin
				if (sts.go_long) begin
					cmd.start = 1'b1;
					state_d   = S_ITER;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_ITER: begin
				if (sts.unit_done && out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- rtl/stack_machine_executor_core.sv -----
// Top level of the stack machine executor.
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, instruction_word      | item into block
//  out     | out_valid, out_ready, top_value,          | result out of block
//          | stack_depth, status                       |
// One item at a time. Push, unary ops, pop of the last entry and errors other than
// a zero-base power commit from the decode state. Other binary ops, swap and pop
// pass through the operand state first. Multiply, divide/modulo, square root, cube
// root and power then run in the shared iterative unit before they commit. A new
// item is taken while a result waits; that item's commit stalls until the result
// is taken. Reset empties the stack.
module stack_machine_executor_core #(
	parameter int STACK_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instruction_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] top_value,
	output logic [8:0]         stack_depth,
	output logic [2:0]         status
);
	import sme_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sme_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.instruction_word (instruction_word),
		.top_value        (top_value),
		.stack_depth      (stack_depth),
		.status           (status)
	);
endmodule

// ----- rtl/sme_checker.sv -----
// Port-level checks for the stack machine executor, bound to the top level.
module sme_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [31:0]       instruction_word,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [31:0] top_value,
	input logic [8:0]        stack_depth,
	input logic [2:0]        status
);
	import sme_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(status))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_depth == 9'd0 |-> top_value == 32'sd0)
		else $error("empty stack shows nonzero top");

	a_under_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNDER |-> stack_depth < 9'd2)
		else $error("underflow reported with enough operands");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");
endmodule

bind stack_machine_executor_core sme_checker u_sme_checker (.*);

// ----- tb/stack_machine_executor_core_test.sv -----
// Testbench for the stack machine executor: directed table, random programs, self-checking.
`timescale 1ns / 1ps

module stack_machine_executor_core_test;
	import sme_pkg::*;

	localparam int DEPTH = 256;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 340;
	localparam int TAIL_ITEMS = 90;

	typedef struct packed {
		logic [31:0] top;
		logic [8:0]  depth;
		logic [2:0]  status;
	} result_t;

	typedef struct {
		logic [31:0] word;
		bit          typed;
		result_t     want;
	} vector_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        instruction_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] top_value;
	logic [8:0]         stack_depth;
	logic [2:0]         status;

	stack_machine_executor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.instruction_word(instruction_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.top_value(top_value),
		.stack_depth(stack_depth),
		.status(status)
	);

	always #6 clk = ~clk;

	// shadow machine state
	logic [31:0] stk [DEPTH];
	int          sp = 0;
	bit          halted = 1'b0;

	result_t pending_results [$];
	int      errors = 0;
	int      items_sent = 0;
	int      results_seen = 0;
	int      max_sp = 0;
	int      status_hits [8];
	bit      quiet = 1'b0;
	bit      hold_req = 1'b0;

	function automatic logic [31:0] mag(input logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	function automatic bit takes_pair(input logic [5:0] op);
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW, OP_MIN, OP_MAX,
			OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_LT, OP_LE, OP_GT, OP_GE,
			OP_EQ, OP_NE, OP_SWAP, OP_BTST, OP_BCLR, OP_BSET: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [31:0] root2(input logic [31:0] v);
		logic [31:0] r;
		logic [31:0] t;
		r = 0;
		for (int i = 15; i >= 0; i--) begin
			t = r | (32'd1 << i);
			if (64'(t) * 64'(t) <= 64'(v))
				r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] root3(input logic [31:0] v);
		logic [31:0] m;
		logic [31:0] r;
		logic [63:0] t;
		m = mag(v);
		r = 0;
		for (int i = 10; i >= 0; i--) begin
			t = 64'(r | (32'd1 << i));
			if (t * t * t <= 64'(m))
				r = t[31:0];
		end
		return v[31] ? -r : r;
	endfunction

	function automatic logic [31:0] power(input logic [31:0] base, input logic [31:0] e);
		logic [31:0] acc;
		acc = 1;
		while (e != 0) begin
			if (e[0])
				acc = acc * base;
			base = base * base;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic result_t run_instruction(input logic [31:0] w);
		result_t     r;
		logic [29:0] pl;
		logic [5:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] v;
		logic [4:0]  sh;
		logic [2:0]  st;
		bit          two;
		bit          wr;
		pl = w[29:0];
		st = ST_OK;
		if (halted) begin
			st = ST_IGNORED;
		end else if (w[31:30] == K_PUSH || w[31:30] == K_NEG) begin
			if (sp >= DEPTH) begin
				st = ST_OVER;
			end else begin
				stk[sp] = (w[31:30] == K_NEG) ? -{2'b00, pl} : {2'b00, pl};
				sp++;
			end
		end else if (w[31:30] == K_PRIM) begin
			if (pl > OP_LAST || pl == OP_RAND) begin
				st = ST_INVALID;
			end else begin
				op = pl[5:0];
				if (op == OP_HALT) begin
					halted = 1'b1;
					st = ST_HALT;
				end else begin
					two = takes_pair(op);
					if (sp < (two ? 2 : 1)) begin
						st = ST_UNDER;
					end else begin
						b = stk[sp-1];
						a = two ? stk[sp-2] : 32'd0;
						sh = b[4:0];
						wr = 1'b1;
						v = 0;
						case (op)
							OP_ADD: v = a + b;
							OP_SUB: v = a - b;
							OP_MUL: v = a * b;
							OP_DIV: begin
								if (b == 0) begin
									st = ST_DIVZERO;
								end else begin
									v = mag(a) / mag(b);
									if (a[31] != b[31])
										v = -v;
								end
							end
							OP_MOD: begin
								if (b == 0) begin
									st = ST_DIVZERO;
								end else begin
									v = mag(a) % mag(b);
									if (a[31])
										v = -v;
								end
							end
							OP_SQRT: begin
								if (b[31])
									st = ST_NEGROOT;
								else
									v = root2(b);
							end
							OP_CBRT: v = root3(b);
							OP_POW: begin
								if (!b[31])
									v = power(a, b);
								else if (a == 0)
									st = ST_DIVZERO;
								else if (a == 1)
									v = 1;
								else if (a == 32'hffff_ffff)
									v = b[0] ? 32'hffff_ffff : 32'd1;
								else
									v = 0;
							end
							OP_MIN: v = ($signed(a) < $signed(b)) ? a : b;
							OP_MAX: v = ($signed(a) > $signed(b)) ? a : b;
							OP_AND: v = a & b;
							OP_OR: v = a | b;
							OP_XOR: v = a ^ b;
							OP_NOT: v = ~b;
							OP_SHL: v = a << sh;
							OP_SHR: v = $signed(a) >>> sh;
							OP_NEGT: v = -b;
							OP_LT: v = 32'($signed(a) < $signed(b));
							OP_LE: v = 32'($signed(a) <= $signed(b));
							OP_GT: v = 32'($signed(a) > $signed(b));
							OP_GE: v = 32'($signed(a) >= $signed(b));
							OP_EQ: v = 32'(a == b);
							OP_NE: v = 32'(a != b);
							OP_SWAP: begin
								stk[sp-1] = a;
								stk[sp-2] = b;
								wr = 1'b0;
							end
							OP_INC: v = b + 1;
							OP_DEC: v = b - 1;
							OP_BTST: v = 32'(a[sh]);
							OP_BCLR: v = a & ~(32'd1 << sh);
							OP_BSET: v = a | (32'd1 << sh);
							OP_POP: begin
								sp--;
								wr = 1'b0;
							end
							OP_EVEN: v = 32'(!b[0]);
							OP_ODD: v = 32'(b[0]);
							default: st = ST_INVALID;
						endcase
						if (st == ST_OK && wr) begin
							if (two)
								sp--;
							stk[sp-1] = v;
						end
					end
				end
			end
		end else begin
			st = ST_INVALID;
		end
		r.top = (sp != 0) ? stk[sp-1] : 32'd0;
		r.depth = 9'(sp);
		r.status = st;
		if (sp > max_sp)
			max_sp = sp;
		return r;
	endfunction

	function automatic logic [31:0] prim(input logic [5:0] op);
		return {K_PRIM, 24'd0, op};
	endfunction

	function automatic logic [31:0] push(input logic [29:0] v);
		return {K_PUSH, v};
	endfunction

	function automatic logic [31:0] push_neg(input logic [29:0] v);
		return {K_NEG, v};
	endfunction

	function automatic vector_t row(input logic [31:0] w, input bit typed = 0,
			input logic [31:0] t = 0, input logic [8:0] d = 0, input logic [2:0] s = 0);
		vector_t x;
		x.word = w;
		x.typed = typed;
		x.want = '{top: t, depth: d, status: s};
		return x;
	endfunction

	function automatic logic [29:0] operand();
		case ($urandom_range(0, 5))
			0: return 30'($urandom_range(0, 40));
			1: return 30'h3fff_ffff;
			2: return 30'($urandom_range(0, 31));
			default: return 30'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (sp < 2 && pick < 70)
			pick = 0;
		if (sp > 24 && pick < 45)
			pick = 50;
		if (pick < 45)
			return $urandom_range(0, 1) ? push(operand()) : push_neg(operand());
		else if (pick < 92)
			return prim(6'($urandom_range(1, 33)));
		else if (pick < 95)
			return {K_PRIM, 30'($urandom_range(34, 'h3fff_ffff))};
		else if (pick < 97)
			return {K_PRIM, 30'(OP_RAND)};
		else
			return {K_BAD, 30'($urandom)};
	endfunction

	task automatic send(input logic [31:0] w, input bit use_table, input result_t want);
		result_t got;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = run_instruction(w);
		pending_results.push_back(use_table ? want : got);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				status_hits[status]++;
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected: top %h depth %0d status %0d",
						$time, top_value, stack_depth, status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (top_value !== want.top) begin
						$display("%0t: top_value expected %h actual %h",
							$time, want.top, top_value);
						errors++;
					end
					if (stack_depth !== want.depth) begin
						$display("%0t: stack_depth expected %0d actual %0d",
							$time, want.depth, stack_depth);
						errors++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						errors++;
					end
				end
			end
		end
	end

	// result side: random stalls, plus one long hold on request
	int hold_cnt = 0;
	int gap_cnt = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (gap_cnt > 0) begin
			gap_cnt--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			gap_cnt = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog, no progress", $time);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	vector_t vectors [$];
	result_t unused = '0;

	initial begin
		vectors = '{
			row(prim(OP_ADD), 1, 0, 0, ST_UNDER),
			row(prim(OP_POP), 1, 0, 0, ST_UNDER),
			row({K_BAD, 30'h3fff_ffff}, 1, 0, 0, ST_INVALID),
			row({K_PRIM, 30'(OP_RAND)}, 1, 0, 0, ST_INVALID),
			row({K_PRIM, 30'd34}, 1, 0, 0, ST_INVALID),
			row({K_PRIM, 30'h3fff_ffff}, 1, 0, 0, ST_INVALID),
			row(push(30'h3fff_ffff), 1, 32'h3fff_ffff, 1, ST_OK),
			row(push_neg(30'h3fff_ffff), 1, 32'hc000_0001, 2, ST_OK),
			row(push_neg(30'd0), 1, 0, 3, ST_OK),
			row(push(30'd0), 1, 0, 4, ST_OK),
			row(prim(OP_DIV), 1, 0, 4, ST_DIVZERO),
			row(prim(OP_MOD), 1, 0, 4, ST_DIVZERO),
			row(push(30'd1)),
			row(push(30'd31)),
			row(prim(OP_SHL)),
			row(prim(OP_SQRT)),
			row(prim(OP_CBRT)),
			row(push_neg(30'd1)),
			row(prim(OP_DIV)),
			row(push_neg(30'd1)),
			row(prim(OP_MOD)),
			row(push_neg(30'd3)),
			row(prim(OP_POW)),
			row(push(30'd7)),
			row(prim(OP_POW))
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i])
			send(vectors[i].word, vectors[i].typed, vectors[i].want);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++)
			send(random_word(), 0, unused);
		drain();

		// fill to the top while results back up, then overflow
		hold_req = 1'b1;
		while (sp < DEPTH)
			send($urandom_range(0, 1) ? push(operand()) : push_neg(operand()), 0, unused);
		for (int i = 0; i < 3; i++)
			send(push(operand()), 0, unused);
		for (int i = 0; i < 40; i++)
			send(prim(6'($urandom_range(1, 33))), 0, unused);
		while (sp > 4)
			send(prim(OP_POP), 0, unused);

		quiet = 1'b1;
		for (int i = 0; i < TAIL_ITEMS; i++)
			send(random_word(), 0, unused);
		send(prim(OP_HALT), 0, unused);
		send(push(30'd5), 0, unused);
		send({K_BAD, 30'd0}, 0, unused);
		send(prim(OP_ADD), 0, unused);
		drain();
		repeat (80) @(posedge clk);

		$display("Ran %0d instructions, %0d results checked, deepest stack %0d.",
			items_sent, results_seen, max_sp);
		$display("Status counts ok..invalid: %0d %0d %0d %0d %0d %0d %0d %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
		if (errors == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sme_pkg.sv
rtl/sme_ram.sv
rtl/sme_iter.sv
rtl/sme_dpath.sv
rtl/sme_ctrl.sv
rtl/stack_machine_executor_core.sv
rtl/sme_checker.sv
tb/stack_machine_executor_core_test.sv
